@@ design/opre_pkg.sv @@
// Shared types, constants and fixed-point helpers for the orthogonal polynomial
// recurrence evaluator. No dependencies; imported by the core, the checker and the testbench.
package opre_pkg;

  // Widths and limits of the number format and the coefficient table
  localparam int DataW     = 32;
  localparam int FracBits  = 16;
  localparam int MaxDegree = 16;
  localparam int RowW      = $clog2(MaxDegree);
  localparam int DegW      = $clog2(MaxDegree + 1);
  localparam int TermW     = 2;
  localparam int NumTerms  = 3;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] OneFx  = DataW'(1) << FracBits;

  // Request codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [TermW-1:0] TERM_A0 = 2'd0;
  localparam logic [TermW-1:0] TERM_A1 = 2'd1;
  localparam logic [TermW-1:0] TERM_A2 = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic                    mode;
    logic [RowW-1:0]         row;
    logic [TermW-1:0]        term;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    saturated;
  } rsp_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    clip;
  } sat_t;

  typedef logic [NumTerms-1:0][DataW-1:0] coef_row_t;

  // Fixed-point product: floor shift by FracBits, then clip to the data range
  function automatic sat_t fx_mul(input logic signed [DataW-1:0] a,
                                  input logic signed [DataW-1:0] b);
    logic signed [2*DataW-1:0]        p;
    logic signed [2*DataW-FracBits-1:0] q;
    logic                             fits;
    sat_t                             r;
    p    = a * b;
    q    = p[2*DataW-1:FracBits];
    fits = (&q[2*DataW-FracBits-1:DataW-1]) | ~(|q[2*DataW-FracBits-1:DataW-1]);
    r.clip = ~fits;
    if (fits) begin
      r.val = q[DataW-1:0];
    end else if (q[2*DataW-FracBits-1]) begin
      r.val = SatMin;
    end else begin
      r.val = SatMax;
    end
    return r;
  endfunction

  // Saturating sum of two data words
  function automatic sat_t sat_add(input logic signed [DataW-1:0] a,
                                   input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    sat_t                  r;
    s      = {a[DataW-1], a} + {b[DataW-1], b};
    r.clip = s[DataW] ^ s[DataW-1];
    if (!r.clip) begin
      r.val = s[DataW-1:0];
    end else if (s[DataW]) begin
      r.val = SatMin;
    end else begin
      r.val = SatMax;
    end
    return r;
  endfunction

endpackage

@@ design/orthogonal_poly_recurrence_eval_core.sv @@
// Orthogonal polynomial evaluator core: coefficient table memory, pipelined
// three-term recurrence in reverse order. Depends on opre_pkg.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. A load
//   request (mode load) writes one coefficient word, row/term, into the table
//   at that edge and gives no result; busy stays low, so loads can follow back
//   to back. An evaluate request gives exactly one result on rsp_o, marked by
//   done_o for one cycle; the receiver cannot stall it. The user must write the
//   degree register (cfg_we_i/cfg_wdata_i) only while idle; the block does not
//   enforce this. Values above the table size are treated as the table size.
// Timing:
//   Degree 0: the result (1.0) shows in the cycle after the request, busy stays low.
//   Degree n >= 1: the table is read one row per cycle from row n-1 down to 0
//   through a single registered read port; each row passes a product stage, a
//   sum stage and the shared multiply-add of the recurrence. The result shows
//   when busy falls, in that same cycle; no new request is taken while an
//   evaluate is in flight.
// Reset:
//   rst_ni clears the control state and the degree register (to 0). The
//   table is not cleared; rows must be loaded before they are evaluated.
module orthogonal_poly_recurrence_eval_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  opre_pkg::req_t              req_i,
  output logic                        done_o,
  output opre_pkg::rsp_t              rsp_o,
  input  logic                        cfg_we_i,
  input  logic [opre_pkg::DegW-1:0]   cfg_wdata_i
);
  import opre_pkg::*;

  // Coefficient table: one row of (a0, a1, a2) per recurrence step
  coef_row_t coef_mem_q [MaxDegree];
  coef_row_t rd_data_q;

  state_e state_q, state_d;

  logic [DegW-1:0]         degree_q;
  logic [DegW-1:0]         n_clamp;
  logic [DegW-1:0]         n_q;
  logic [RowW-1:0]         rd_row_q;
  logic                    rd_en;
  logic                    req_acc;
  logic                    load_we;
  logic                    eval_go;
  logic signed [DataW-1:0] x_q;

  // Pipeline tags
  logic s1_vld_q, s1_first_q, s1_last_q;
  logic s2_vld_q, s2_first_q, s2_last_q;
  logic s3_vld_q, s3_first_q, s3_last_q;

  // Pipeline payload
  sat_t                    p0;
  sat_t                    lin;
  sat_t                    m_lin;
  sat_t                    m_a2;
  sat_t                    w;
  logic signed [DataW-1:0] prod_q;
  logic signed [DataW-1:0] s2_a1_q;
  logic signed [DataW-1:0] s2_a2_q;
  logic signed [DataW-1:0] lin_q;
  logic signed [DataW-1:0] s3_a2_q;
  logic signed [DataW-1:0] u_q;
  logic signed [DataW-1:0] v_q;
  logic signed [DataW-1:0] a2_prev_q;
  logic                    flag_q;
  logic                    step_clip;

  logic done_q;
  rsp_t rsp_q;

  // Request decode
  assign req_acc = start && !busy;
  assign load_we = req_acc && (req_i.mode == MODE_LOAD) &&
                   (req_i.term inside {TERM_A0, TERM_A1, TERM_A2});
  assign n_clamp = (degree_q > DegW'(MaxDegree)) ? DegW'(MaxDegree) : degree_q;
  assign eval_go = req_acc && (req_i.mode == MODE_EVAL) && (n_clamp != '0);

  // Degree register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_go) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_row_q == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_vld_q && s3_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_q)
      ST_IDLE:  busy  = 1'b0;
      ST_READ:  rd_en = 1'b1;
      ST_DRAIN: rd_en = 1'b0;
      default:  busy  = 1'b1;
    endcase
  end

  // Sequencer: row counter walks from the top row down to row 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_row_q <= '0;
      n_q      <= '0;
    end else begin
      state_q <= state_d;
      if (eval_go) begin
        n_q      <= n_clamp;
        rd_row_q <= RowW'(n_clamp - DegW'(1));
      end else if (rd_en && rd_row_q != '0) begin
        rd_row_q <= rd_row_q - RowW'(1);
      end
    end
  end

  // Hold the evaluation point
  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      x_q <= req_i.value;
    end
  end

  // Table write on load, registered read of one row per cycle
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      coef_mem_q[req_i.row][req_i.term] <= req_i.value;
    end
    if (rd_en) begin
      rd_data_q <= coef_mem_q[rd_row_q];
    end
  end

  // Stage math: a0*x, then +a1, then the recurrence multiply-add
  assign p0    = fx_mul($signed(rd_data_q[TERM_A0]), x_q);
  assign lin   = sat_add(prod_q, s2_a1_q);
  assign m_lin = fx_mul(lin_q, v_q);
  assign m_a2  = fx_mul(a2_prev_q, u_q);
  assign w     = sat_add(m_lin.val, m_a2.val);
  assign step_clip = !s3_first_q && (m_lin.clip || m_a2.clip || w.clip);

  // Valid and tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_vld_q   <= 1'b0;
      s3_first_q <= 1'b0;
      s3_last_q  <= 1'b0;
    end else begin
      s1_vld_q   <= rd_en;
      s1_first_q <= ({1'b0, rd_row_q} == (n_q - DegW'(1)));
      s1_last_q  <= (rd_row_q == '0);
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s3_vld_q   <= s2_vld_q;
      s3_first_q <= s2_first_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // Product and sum stages
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q  <= p0.val;
      s2_a1_q <= rd_data_q[TERM_A1];
      s2_a2_q <= rd_data_q[TERM_A2];
    end
    if (s2_vld_q) begin
      lin_q   <= lin.val;
      s3_a2_q <= s2_a2_q;
    end
  end

  // Recurrence state: first row seeds v, later rows step it
  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      a2_prev_q <= s3_a2_q;
      if (s3_first_q) begin
        u_q <= OneFx;
        v_q <= lin_q;
      end else begin
        u_q <= v_q;
        v_q <= w.val;
      end
    end
  end

  // Saturation flag: clear on a new evaluation, collect clips from every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (eval_go) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_q | (s1_vld_q && p0.clip) | (s2_vld_q && lin.clip) |
                (s3_vld_q && step_clip);
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (req_acc && (req_i.mode == MODE_EVAL) && (n_clamp == '0)) ||
                (s3_vld_q && s3_last_q);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.mode == MODE_EVAL) && (n_clamp == '0)) begin
      rsp_q.result    <= OneFx;
      rsp_q.saturated <= 1'b0;
    end else if (s3_vld_q && s3_last_q) begin
      rsp_q.result    <= s3_first_q ? lin_q : w.val;
      rsp_q.saturated <= flag_q | step_clip;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ verif/poly_eval_checker.sv @@
// Checker for the orthogonal polynomial recurrence evaluator: watches the request,
// result and degree ports, predicts each evaluate and compares field by field.
// Depends on opre_pkg for the request and result types.
module poly_eval_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  opre_pkg::req_t            req_i,
  input  logic                      done_o,
  input  opre_pkg::rsp_t            rsp_i,
  input  logic                      cfg_we_i,
  input  logic [opre_pkg::DegW-1:0] cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import opre_pkg::*;

  // Shadow copy of the coefficient table and the degree register
  logic signed [DataW-1:0] coef_tbl [MaxDegree][NumTerms];
  logic [DegW-1:0]         degree_q;
  rsp_t                    poly_value_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Clip a wide value to the data word, flag when clipped
  function automatic longint clip_word(input longint v, inout bit sat);
    if (v > longint'(SatMax)) begin
      sat = 1'b1;
      return longint'(SatMax);
    end
    if (v < longint'(SatMin)) begin
      sat = 1'b1;
      return longint'(SatMin);
    end
    return v;
  endfunction

  // Fixed-point product with floor shift, then clip
  function automatic longint fx_product(input longint a, input longint b, inout bit sat);
    longint p;
    p = a * b;
    return clip_word(p >>> FracBits, sat);
  endfunction

  // a0*x + a1 of one recurrence row
  function automatic longint row_linear(input int r, input longint x, inout bit sat);
    longint m;
    m = fx_product(longint'(coef_tbl[r][TERM_A0]), x, sat);
    return clip_word(m + longint'(coef_tbl[r][TERM_A1]), sat);
  endfunction

  // Evaluate P(d) at x, walking the rows from the top down
  function automatic rsp_t eval_poly(input logic signed [DataW-1:0] x);
    longint u;
    longint v;
    longint w;
    longint lin;
    int     n;
    bit     sat;
    rsp_t   r;
    n   = (degree_q > MaxDegree) ? MaxDegree : int'(degree_q);
    sat = 1'b0;
    if (n == 0) begin
      v = longint'(OneFx);
    end else begin
      u = longint'(OneFx);
      v = row_linear(n - 1, longint'(x), sat);
      for (int k = n - 1; k > 0; k--) begin
        lin = row_linear(k - 1, longint'(x), sat);
        w = clip_word(fx_product(lin, v, sat) +
                      fx_product(longint'(coef_tbl[k][TERM_A2]), u, sat), sat);
        u = v;
        v = w;
      end
    end
    r.result    = v[DataW-1:0];
    r.saturated = sat;
    return r;
  endfunction

  // Sample all channels at the rising edge: results first, then new requests
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      degree_q     = '0;
      poly_value_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare a finished evaluate with the oldest prediction
      if (done_o === 1'b1) begin
        if (poly_value_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no evaluate waiting", rsp_i.result));
        end else begin
          exp_rsp = poly_value_q.pop_front();
          if (rsp_i.result !== exp_rsp.result)
            report_mismatch($sformatf("result %h, predicted %h",
                                      rsp_i.result, exp_rsp.result));
          if (rsp_i.saturated !== exp_rsp.saturated)
            report_mismatch($sformatf("saturated %b, predicted %b (result %h)",
                                      rsp_i.saturated, exp_rsp.saturated, rsp_i.result));
        end
      end
      // apply an accepted request
      if (start === 1'b1 && busy === 1'b0) begin
        if (req_i.mode == MODE_EVAL) begin
          poly_value_q.push_back(eval_poly(req_i.value));
        end else if (req_i.term < NumTerms && req_i.row < MaxDegree) begin
          coef_tbl[req_i.row][req_i.term] = req_i.value;
        end
      end
      // track the degree register
      if (cfg_we_i === 1'b1) begin
        degree_q = cfg_wdata_i;
      end
      pending_o = poly_value_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the evaluator testbench: clock, reset, request stimulus, degree writes,
// watchdog and verdict. Depends on opre_pkg, the core and poly_eval_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import opre_pkg::*;

  localparam logic [TermW-1:0] TERM_IGNORED = 2'd3;
  localparam int ItemTarget  = 1200;
  localparam int DrainCycles = 24;
  localparam int WatchLimit  = 1000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  req_t            req;
  logic            done;
  rsp_t            rsp;
  logic            cfg_we;
  logic [DegW-1:0] cfg_wdata;
  int              fail_count;
  int              pending;
  int unsigned     items_sent;
  int unsigned     idle_cycles;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  orthogonal_poly_recurrence_eval_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  poly_eval_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .done_o       (done),
    .rsp_i        (rsp),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Hold a request until the core takes it
  task automatic send_request(input req_t r);
    @(negedge clk_i);
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (r.mode == MODE_EVAL || r.term != TERM_IGNORED) items_sent++;
  endtask

  task automatic send_load(input int row, input logic [TermW-1:0] term,
                           input logic signed [DataW-1:0] value);
    req_t r;
    r.mode  = MODE_LOAD;
    r.row   = row[RowW-1:0];
    r.term  = term;
    r.value = value;
    send_request(r);
  endtask

  task automatic send_eval(input logic signed [DataW-1:0] x);
    req_t r;
    r.mode  = MODE_EVAL;
    r.row   = RowW'($urandom);
    r.term  = TermW'($urandom);
    r.value = x;
    send_request(r);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drop start, wait for every evaluate to finish, then let the pipeline settle
  task automatic drain_requests();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_degree(input logic [DegW-1:0] d);
    drain_requests();
    cfg_we    = 1'b1;
    cfg_wdata = d;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // Mostly values within +/- span, some full-range words and some extremes
  function automatic logic signed [DataW-1:0] rand_word(input int span);
    case ($urandom_range(0, 9))
      0: return DataW'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return SatMax;
          1: return SatMin;
          2: return '0;
          3: return OneFx;
          default: return -OneFx;
        endcase
      end
      default: return DataW'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Stimulus
  initial begin
    int deg;
    int n_rows;
    int gap;
    bit no_gaps;
    logic signed [DataW-1:0] coef;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // degree after reset is zero: reads no table entry
    send_eval(SatMax);
    send_eval(SatMin);

    // fill the whole table with a Chebyshev recurrence
    for (int r = 0; r < MaxDegree; r++) begin
      send_load(r, TERM_A0, (r == 0) ? OneFx : 2 * OneFx);
      send_load(r, TERM_A1, '0);
      send_load(r, TERM_A2, -OneFx);
    end
    // unused term code: must leave row 5 alone
    send_load(5, TERM_IGNORED, SatMax);

    write_degree(DegW'(1));
    send_eval(SatMax);
    send_eval(SatMin);
    send_eval('0);
    send_eval(OneFx);
    send_eval(-OneFx);
    // clip both the product and the sum in row 0
    send_load(0, TERM_A0, SatMax);
    send_load(0, TERM_A1, SatMax);
    send_eval(SatMax);
    send_load(0, TERM_A0, SatMin);
    send_load(0, TERM_A1, SatMin);
    send_eval(SatMax);
    send_load(0, TERM_A0, OneFx);
    send_load(0, TERM_A1, '0);

    write_degree(DegW'(MaxDegree));
    send_eval(OneFx / 2);
    send_eval(SatMax);
    send_eval(SatMin);
    // degree beyond the table is capped at the table size
    write_degree({DegW{1'b1}});
    send_eval(-(OneFx / 3));

    // random phases: new degree, optional well-formed table, then a burst
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 19))
        0: deg = 0;
        1: deg = 1;
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: deg = $urandom_range(2, 6);
        12, 13, 14, 15: deg = $urandom_range(7, 15);
        16, 17: deg = MaxDegree;
        default: deg = $urandom_range(MaxDegree + 1, (1 << DegW) - 1);
      endcase
      write_degree(deg[DegW-1:0]);
      n_rows  = (deg > MaxDegree) ? MaxDegree : deg;
      no_gaps = ($urandom_range(0, 3) == 0);

      // reload the rows in use with a slightly perturbed Chebyshev set
      if ($urandom_range(0, 3) == 0) begin
        for (int r = 0; r < n_rows; r++) begin
          for (int t = 0; t < NumTerms; t++) begin
            case (t)
              0: coef = ((r == 0) ? OneFx : 2 * OneFx) + int'($urandom_range(0, 2000)) - 1000;
              1: coef = int'($urandom_range(0, 2000)) - 1000;
              default: coef = -OneFx + int'($urandom_range(0, 2000)) - 1000;
            endcase
            send_load(r, TermW'(t), coef);
          end
        end
      end

      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 9) < 6) begin
          send_eval(rand_word(OneFx));
        end else begin
          send_load($urandom_range(0, MaxDegree - 1),
                    ($urandom_range(0, 15) == 0) ? TERM_IGNORED : TermW'($urandom_range(0, 2)),
                    rand_word(2 * OneFx));
        end
        if (!no_gaps) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: gap = 0;
            14, 15, 16, 17: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(5, 40);
          endcase
          idle_for(gap);
        end
      end
    end

    // wait for the last results, then give the verdict
    drain_requests();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done || cfg_we || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no activity for %0d cycles, %0d results pending", WatchLimit, pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule
